// ===== src/mpba_pkg.sv =====
// Package for the multi-pool block allocator: sizes, codes and state encoding.
// No dependencies.
package mpba_pkg;
    localparam int POOLS_DEF      = 8;
    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam logic [1:0] FUNC_CREATE  = 2'd0;
    localparam logic [1:0] FUNC_ALLOC   = 2'd1;
    localparam logic [1:0] FUNC_FREE    = 2'd2;
    localparam logic [1:0] FUNC_DESTROY = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD     = 3'd1;
    localparam logic [2:0] ST_EXHAUST = 3'd2;
    localparam logic [2:0] ST_FOREIGN = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_INUSE   = 3'd5;

    localparam logic [0:0] REG_OOM_MASK = 1'd0;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_CHAIN = 6'b000100,
        S_ARD   = 6'b001000,
        S_AFIN  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;
endpackage

// ===== src/multi_pool_block_allocator.sv =====
// Top level of the multi-pool block allocator: sequencer, pool table, link memory.
// Depends on mpba_pkg.
//
// Handles one command at a time. A successful allocate goes through S_ARD and
// S_AFIN to S_OUT (link memory read with registered data). An allocate on an
// exhausted pool goes straight to S_OUT, and so do free, destroy and rejected
// commands. Create runs a restoring divider one quotient bit a cycle, then writes
// the chain one link a cycle (skipped when no block fits) before S_OUT. The result
// is held in an output register until taken; a new command is taken only after it
// has been transferred. The link memory holds POOLS*MAX_BLOCKS entries and needs
// no clearing pass: create writes every link a pool can reach before use.
module multi_pool_block_allocator #(
    parameter int POOLS      = mpba_pkg::POOLS_DEF,
    parameter int MAX_BLOCKS = mpba_pkg::MAX_BLOCKS_DEF,
    parameter int PAGE_BYTES = mpba_pkg::PAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[1:0], pool_id[4:2], block_index[14:5], page_count[22:15],
    // block_bytes[38:23], zero pad
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], new_pool_id[5:3], granted_block[15:6], oom_notify[16],
    // used_count[27:17], peak_count[38:28], total_count[49:39],
    // alloc_total[81:50], free_total[113:82], zero pad
    output logic [119:0] m_axis_tdata
);
    import mpba_pkg::*;

    localparam int PW = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int BW = $clog2(MAX_BLOCKS);
    localparam int CW = BW + 1;          // counts up to MAX_BLOCKS
    localparam int AW = PW + BW;
    localparam int NW = $clog2(POOLS + 1);
    localparam logic [CW-1:0] LINK_END = CW'(MAX_BLOCKS);

    // config
    logic [7:0] r_mask;
    assign pready = 1'b1;
    assign prdata = (paddr == {REG_OOM_MASK, 1'b0}) ? {24'd0, r_mask} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (psel && penable && pwrite && paddr == {REG_OOM_MASK, 1'b0}) begin
            r_mask <= pwdata[7:0];
        end
    end

    // input fields
    logic [1:0]  in_func;
    logic [2:0]  in_pid;
    logic [9:0]  in_blk;
    logic [7:0]  in_pages;
    logic [15:0] in_bytes;
    assign in_func  = s_axis_tdata[1:0];
    assign in_pid   = s_axis_tdata[4:2];
    assign in_blk   = s_axis_tdata[14:5];
    assign in_pages = s_axis_tdata[22:15];
    assign in_bytes = s_axis_tdata[38:23];

    // pool table
    logic [POOLS-1:0] r_active;
    logic [NW-1:0]    r_created;
    logic [CW-1:0]    r_total [POOLS];
    logic [CW-1:0]    r_used  [POOLS];
    logic [CW-1:0]    r_peak  [POOLS];
    logic [31:0]      r_acnt  [POOLS];
    logic [31:0]      r_fcnt  [POOLS];
    logic [CW-1:0]    r_head  [POOLS];

    logic [CW-1:0] link_mem [POOLS*MAX_BLOCKS];
    logic [CW-1:0] r_link_q;

    t_state        r_state;
    logic [PW-1:0] r_pid;
    logic [1:0]    r_func;
    logic [31:0]   r_num, r_rem;
    logic [15:0]   r_div;
    logic [5:0]    r_step;
    logic [CW-1:0] r_k, r_n;

    logic [2:0]    r_st;
    logic [2:0]    r_npid;
    logic [9:0]    r_gnt;
    logic          r_oom;
    logic          r_zero;   // report zero counters

    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    assign rem_sh  = {r_rem, r_num[31]};
    assign rem_sub = rem_sh - {17'd0, r_div};

    logic          link_we;
    logic [AW-1:0] link_wa;
    logic [CW-1:0] link_wd;
    logic [AW-1:0] link_ra;

    assign s_axis_tready = (r_state == S_IDLE);
    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;
    logic pid_ok;
    assign pid_ok = ({1'b0, in_pid} < 4'(r_created)) && (32'(in_pid) < POOLS);

    always_comb begin
        link_we = 1'b0;
        link_wa = {r_pid, r_k[BW-1:0]};
        link_wd = r_k + 1'b1;
        link_ra = {r_pid, r_head[r_pid][BW-1:0]};
        if (r_state == S_CHAIN) begin
            link_we = 1'b1;
            if (r_k + 1'b1 >= r_n) link_wd = LINK_END;
        end else if (r_state == S_IDLE && acc && in_func == FUNC_FREE && pid_ok &&
                     r_active[in_pid[PW-1:0]] &&
                     {1'b0, in_blk} < 11'(r_total[in_pid[PW-1:0]]) &&
                     32'(in_blk) < MAX_BLOCKS) begin
            link_we = 1'b1;
            link_wa = {in_pid[PW-1:0], in_blk[BW-1:0]};
            link_wd = r_head[in_pid[PW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) link_mem[link_wa] <= link_wd;
        r_link_q <= link_mem[link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_created <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (acc) begin
                    r_pid  <= in_pid[PW-1:0];
                    r_func <= in_func;
                    r_npid <= '0;
                    r_gnt  <= '0;
                    r_oom  <= 1'b0;
                    r_zero <= 1'b0;
                    r_st   <= ST_OK;
                    r_state <= S_OUT;
                    if (in_func == FUNC_CREATE) begin
                        if (32'(r_created) >= POOLS) begin
                            r_st <= ST_FULL; r_zero <= 1'b1;
                        end else begin
                            r_pid  <= r_created[PW-1:0];
                            r_num  <= 32'(in_pages) * 32'(PAGE_BYTES);
                            r_div  <= (in_bytes < 16'd8) ? 16'd8 : in_bytes;
                            r_rem  <= '0;
                            r_step <= '0;
                            r_state <= S_DIV;
                        end
                    end else if (!pid_ok) begin
                        r_st <= ST_BAD; r_zero <= 1'b1;
                    end else if (!r_active[in_pid[PW-1:0]]) begin
                        r_st <= ST_BAD;
                    end else begin
                        case (in_func)
                            FUNC_ALLOC: begin
                                if (r_head[in_pid[PW-1:0]] >= LINK_END) begin
                                    r_st  <= ST_EXHAUST;
                                    r_oom <= r_mask[in_pid];
                                end else begin
                                    r_state <= S_ARD;
                                end
                            end
                            FUNC_FREE: begin
                                if (link_we) begin
                                    r_head[in_pid[PW-1:0]] <= CW'(in_blk);
                                    if (r_used[in_pid[PW-1:0]] != '0)
                                        r_used[in_pid[PW-1:0]] <=
                                            r_used[in_pid[PW-1:0]] - 1'b1;
                                    r_fcnt[in_pid[PW-1:0]] <=
                                        r_fcnt[in_pid[PW-1:0]] + 32'd1;
                                end else begin
                                    r_st <= ST_FOREIGN;
                                end
                            end
                            default: begin
                                if (r_used[in_pid[PW-1:0]] != '0) r_st <= ST_INUSE;
                                else r_active[in_pid[PW-1:0]] <= 1'b0;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit a cycle
                    if (!rem_sub[32]) begin
                        r_rem <= rem_sub[31:0];
                        r_num <= {r_num[30:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[31:0];
                        r_num <= {r_num[30:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 6'd31) r_state <= S_AFIN;
                end
                S_AFIN: begin
                    if (r_func == FUNC_CREATE) begin
                        // r_num holds the quotient
                        if (r_num == '0) begin
                            r_st <= ST_EXHAUST; r_zero <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_n <= (r_num > 32'(MAX_BLOCKS)) ? LINK_END : r_num[CW-1:0];
                            r_k <= '0;
                            r_state <= S_CHAIN;
                        end
                    end else begin
                        r_head[r_pid] <= r_link_q;
                        if (r_used[r_pid] < r_total[r_pid]) begin
                            r_used[r_pid] <= r_used[r_pid] + 1'b1;
                            if (r_used[r_pid] + 1'b1 > r_peak[r_pid])
                                r_peak[r_pid] <= r_used[r_pid] + 1'b1;
                        end
                        r_acnt[r_pid] <= r_acnt[r_pid] + 32'd1;
                        r_state <= S_OUT;
                    end
                end
                S_ARD: begin
                    r_gnt <= 10'(r_head[r_pid]);
                    r_state <= S_AFIN;
                end
                S_CHAIN: begin
                    r_k <= r_k + 1'b1;
                    if (r_k + 1'b1 >= r_n) begin
                        r_active[r_pid] <= 1'b1;
                        r_total[r_pid]  <= r_n;
                        r_used[r_pid]   <= '0;
                        r_peak[r_pid]   <= '0;
                        r_acnt[r_pid]   <= '0;
                        r_fcnt[r_pid]   <= '0;
                        r_head[r_pid]   <= '0;
                        r_created <= r_created + 1'b1;
                        r_npid  <= 3'(r_pid);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[2:0]   = r_st;
        m_axis_tdata[5:3]   = r_npid;
        m_axis_tdata[15:6]  = r_gnt;
        m_axis_tdata[16]    = r_oom;
        if (!r_zero) begin
            m_axis_tdata[27:17]  = 11'(r_used[r_pid]);
            m_axis_tdata[38:28]  = 11'(r_peak[r_pid]);
            m_axis_tdata[49:39]  = 11'(r_total[r_pid]);
            m_axis_tdata[81:50]  = r_acnt[r_pid];
            m_axis_tdata[113:82] = r_fcnt[r_pid];
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while result held");
    a_created_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_created) <= POOLS) else $error("pool count overflow");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
endmodule

// ===== dv/multi_pool_block_allocator_test.sv =====
// Self-checking testbench for the multi-pool block allocator: predicts each result
// from its own pool model and checks every transfer field by field.
// Depends on mpba_pkg and multi_pool_block_allocator.
module multi_pool_block_allocator_test;
    import mpba_pkg::*;

    localparam int NPOOL  = 8;
    localparam int NBLK   = 1024;
    localparam int PGB    = 4096;
    localparam int WDOG   = 20000;

    // highest field first, so status lands in the lowest bits
    typedef struct packed {
        logic [31:0] frees;
        logic [31:0] allocs;
        logic [10:0] total;
        logic [10:0] peak;
        logic [10:0] used;
        logic        oom;
        logic [9:0]  granted;
        logic [2:0]  new_pool;
        logic [2:0]  status;
    } t_alloc_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;

    multi_pool_block_allocator dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  oom_mask;
    int unsigned n_created;
    bit          active   [NPOOL];
    int unsigned blk_total[NPOOL];
    int unsigned used_cnt [NPOOL];
    int unsigned peak_cnt [NPOOL];
    logic [31:0] alloc_cnt[NPOOL];
    logic [31:0] free_cnt [NPOOL];
    int unsigned head     [NPOOL];
    int unsigned link     [NPOOL][NBLK];

    t_alloc_res  expected_q[$];
    int          errors = 0;
    int          idle_cyc = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    function automatic t_alloc_res pool_counters(int p, t_alloc_res r);
        r.used   = used_cnt[p][10:0];
        r.peak   = peak_cnt[p][10:0];
        r.total  = blk_total[p][10:0];
        r.allocs = alloc_cnt[p];
        r.frees  = free_cnt[p];
        return r;
    endfunction

    // Advances the pool model by one command and returns what the block must report.
    function automatic t_alloc_res predict_command(logic [1:0] fn, int pid, int blk,
                                                   int pages, int size);
        t_alloc_res r;
        int unsigned n, p;
        r = '0;
        if (fn == FUNC_CREATE) begin
            if (n_created >= NPOOL) begin
                r.status = ST_FULL;
                return r;
            end
            if (size < 8) size = 8;
            n = (pages * PGB) / size;
            if (n > NBLK) n = NBLK;
            if (n == 0) begin
                r.status = ST_EXHAUST;
                return r;
            end
            p = n_created;
            active[p] = 1; blk_total[p] = n; used_cnt[p] = 0; peak_cnt[p] = 0;
            alloc_cnt[p] = 0; free_cnt[p] = 0; head[p] = 0;
            for (int k = 0; k + 1 < n; k++) link[p][k] = k + 1;
            link[p][n-1] = NBLK;
            n_created = p + 1;
            r.status = ST_OK;
            r.new_pool = p[2:0];
            return pool_counters(p, r);
        end
        if (pid >= n_created) begin
            r.status = ST_BAD;
            return r;
        end
        if (!active[pid]) begin
            r.status = ST_BAD;
            return pool_counters(pid, r);
        end
        case (fn)
            FUNC_ALLOC: begin
                if (head[pid] >= NBLK) begin
                    r.status = ST_EXHAUST;
                    r.oom = oom_mask[pid];
                end else begin
                    r.granted = head[pid][9:0];
                    head[pid] = link[pid][head[pid]];
                    if (used_cnt[pid] < blk_total[pid]) used_cnt[pid]++;
                    alloc_cnt[pid]++;
                    if (used_cnt[pid] > peak_cnt[pid]) peak_cnt[pid] = used_cnt[pid];
                    r.status = ST_OK;
                end
            end
            FUNC_FREE: begin
                if (blk >= blk_total[pid]) begin
                    r.status = ST_FOREIGN;
                end else begin
                    link[pid][blk] = head[pid];
                    head[pid] = blk;
                    if (used_cnt[pid] > 0) used_cnt[pid]--;
                    free_cnt[pid]++;
                    r.status = ST_OK;
                end
            end
            default: begin
                if (used_cnt[pid] > 0) r.status = ST_INUSE;
                else begin
                    active[pid] = 0;
                    r.status = ST_OK;
                end
            end
        endcase
        return pool_counters(pid, r);
    endfunction

    // Sends one command, with a random gap ahead of it, and queues its prediction.
    // tvalid stays high after the transfer; the gap or wait_drained drops it.
    task automatic send_command(logic [1:0] fn, int pid, int blk, int pages, int size);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {1'b0, size[15:0], pages[7:0], blk[9:0], pid[2:0], fn};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q.push_back(predict_command(fn, pid, blk, pages, size));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write: setup then access; only done with the block idle.
    task automatic write_oom_mask(logic [7:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'(4 * REG_OOM_MASK);
        pwdata <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        oom_mask = v;
    endtask

    // Receiver: random stall, then compare each transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_alloc_res got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_alloc_res'(m_axis_tdata[113:0]);
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want || m_axis_tdata[119:114] !== '0) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp st=%0d np=%0d gb=%0d oom=%0d u=%0d pk=%0d t=%0d a=%0d f=%0d / got st=%0d np=%0d gb=%0d oom=%0d u=%0d pk=%0d t=%0d a=%0d f=%0d",
                                want.status, want.new_pool, want.granted, want.oom,
                                want.used, want.peak, want.total, want.allocs,
                                want.frees, got.status, got.new_pool, got.granted,
                                got.oom, got.used, got.peak, got.total, got.allocs,
                                got.frees);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WDOG) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Edges: unknown pools, size floor, zero blocks, clamp, foreign block, OOM.
    task automatic test_directed();
        send_command(FUNC_ALLOC, 0, 0, 0, 0);
        send_command(FUNC_FREE, 7, 1023, 0, 0);
        send_command(FUNC_DESTROY, 3, 0, 0, 0);
        send_command(FUNC_CREATE, 7, 0, 0, 1);         // zero pages: no blocks
        send_command(FUNC_CREATE, 0, 0, 1, 65535);     // fewer than one block
        send_command(FUNC_CREATE, 0, 0, 255, 1);       // floor to 8, clamp
        send_command(FUNC_CREATE, 0, 0, 1, 2048);      // two blocks -> pool 1
        send_command(FUNC_ALLOC, 1, 0, 0, 0);
        send_command(FUNC_ALLOC, 1, 0, 0, 0);
        send_command(FUNC_ALLOC, 1, 0, 0, 0);          // exhausted, mask 0xff
        send_command(FUNC_DESTROY, 1, 0, 0, 0);        // in use
        send_command(FUNC_FREE, 1, 2, 0, 0);           // foreign
        send_command(FUNC_FREE, 1, 1023, 0, 0);
        send_command(FUNC_FREE, 1, 0, 0, 0);
        send_command(FUNC_FREE, 1, 0, 0, 0);           // double free
        send_command(FUNC_FREE, 1, 1, 0, 0);
        send_command(FUNC_FREE, 1, 1, 0, 0);           // used saturates at zero
        send_command(FUNC_ALLOC, 1, 0, 0, 0);
        send_command(FUNC_ALLOC, 1, 0, 0, 0);
        send_command(FUNC_ALLOC, 1, 0, 0, 0);
        send_command(FUNC_ALLOC, 1, 0, 0, 0);          // used saturates at total
        send_command(FUNC_DESTROY, 0, 0, 0, 0);        // unused pool retires
        send_command(FUNC_ALLOC, 0, 0, 0, 0);          // destroyed pool
        send_command(FUNC_FREE, 0, 5, 0, 0);
        send_command(FUNC_DESTROY, 0, 0, 0, 0);
    endtask

    // Mostly alloc/free traffic on live pools with a little noise and creates.
    task automatic test_random(int n_items, int pct_send, int pct_recv);
        int sel, pid, live;
        send_idle_pct = pct_send;
        recv_idle_pct = pct_recv;
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(99);
            live = (n_created == 0) ? 0 : n_created - 1;
            pid = (sel < 90) ? $urandom_range(live) : $urandom_range(7);
            if (sel < 4)
                send_command(FUNC_CREATE, $urandom_range(7), $urandom_range(1023),
                             $urandom_range(3), $urandom_range(65535, 1));
            else if (sel < 50)
                send_command(FUNC_ALLOC, pid, $urandom_range(1023), $urandom_range(255),
                             $urandom_range(65535, 1));
            else if (sel < 95)
                send_command(FUNC_FREE, pid,
                             ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                      : $urandom_range(40),
                             $urandom_range(255), $urandom_range(65535, 1));
            else
                send_command(FUNC_DESTROY, pid, $urandom_range(1023),
                             $urandom_range(255), $urandom_range(65535, 1));
        end
        wait_drained();
    endtask

    // Fill the rest of the pool table with small pools, then one over the limit.
    task automatic test_table_full();
        while (n_created < NPOOL)
            send_command(FUNC_CREATE, 0, 0, 1, $urandom_range(4096, 100));
        send_command(FUNC_CREATE, 0, 0, 255, 8);
        wait_drained();
    endtask

    initial begin
        oom_mask = '0;
        n_created = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_oom_mask(8'hFF);
        test_directed();
        wait_drained();
        send_command(FUNC_CREATE, 0, 0, 1, 200);       // small pools for traffic
        send_command(FUNC_CREATE, 0, 0, 1, 300);
        wait_drained();                                // sender held until drained
        write_oom_mask(8'h00);
        test_random(270, 7, 78);
        write_oom_mask(8'($urandom_range(255)));
        test_random(270, 78, 7);
        test_table_full();
        write_oom_mask(8'hA5);
        test_random(260, 0, 0);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
